// ===== hdl/rfp_pkg.sv =====
package rfp_pkg;

  localparam int MAX_CODES_DEF  = 16;
  localparam int MAX_DIGITS_DEF = 3;
  localparam int MAX_FRAME_DEF  = 100;

  localparam int FRAME_W = 7;
  localparam int VALUE_W = 10;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int SLOT_W  = 3;

  localparam logic [VALUE_W-1:0] VALUE_CAP = '1;

  localparam logic [KIND_W-1:0] KIND_CODE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TEMP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TIME  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h70;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  code;
    logic [POS_W-1:0]   code_position;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } res_t;

endpackage

// ===== hdl/rfp_in_reg.sv =====
module rfp_in_reg
  import rfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              step,
  output logic              hold_valid,
  output logic [CHAR_W-1:0] hold_char
);

  logic              valid_r;
  logic [CHAR_W-1:0] char_r;

  assign in_ready   = !valid_r || step;
  assign hold_valid = valid_r;
  assign hold_char  = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char;
    end
  end

endmodule

// ===== hdl/rfp_parse.sv =====
module rfp_parse
  import rfp_pkg::*;
#(
  parameter int MAX_CODES  = MAX_CODES_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_FRAME  = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] c,
  output logic              res_valid,
  output res_t              res
);

  localparam int CNT_W = $clog2(MAX_CODES + 1);
  localparam int DIG_W = $clog2(MAX_DIGITS + 1);
  localparam int PROD_W = VALUE_W + 4;

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_CODE       = 3'd1;
  localparam logic [2:0] M_SEP        = 3'd2;
  localparam logic [2:0] M_TAG        = 3'd3;
  localparam logic [2:0] M_BODY_FIRST = 3'd4;
  localparam logic [2:0] M_BODY       = 3'd5;
  localparam logic [2:0] M_DISCARD    = 3'd6;

  logic [2:0]         mode_r,  mode_nxt;
  logic               is_time_r, is_time_nxt;
  logic [CHAR_W-1:0]  tag_r,   tag_nxt;
  logic [VALUE_W-1:0] acc_r,   acc_nxt;
  logic [DIG_W-1:0]   dig_r,   dig_nxt;
  logic               stop_r,  stop_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [FRAME_W-1:0] len_r,   len_nxt;

  logic               is_digit;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] acc_take;
  logic [CHAR_W-1:0]  closer;
  logic [SLOT_W-1:0]  slot_sel;
  logic               slot_ok;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + PROD_W'(4'(c - CH_ZERO));
  assign acc_take = (prod > PROD_W'(VALUE_CAP)) ? VALUE_CAP : prod[VALUE_W-1:0];
  assign closer = is_time_r ? CH_HASH : CH_MINUS;

  always_comb begin
    slot_ok  = 1'b1;
    slot_sel = 3'd0;
    case (tag_r)
      CH_B, CH_C: slot_sel = 3'd0;
      CH_P, CH_E: slot_sel = 3'd1;
      CH_A:       slot_sel = 3'd2;
      CH_F:       slot_sel = 3'd3;
      CH_D:       slot_sel = 3'd4;
      default:    slot_ok  = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    is_time_nxt = is_time_r;
    tag_nxt     = tag_r;
    acc_nxt     = acc_r;
    dig_nxt     = dig_r;
    stop_nxt    = stop_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    res_valid   = 1'b0;
    res         = '0;
    if (step) begin
      if (mode_r == M_DISCARD) begin
        if (c == CH_X) begin
          mode_nxt = M_IDLE;
        end
      end else if (len_r >= FRAME_W'(MAX_FRAME)) begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
        res.code  = c;
        mode_nxt  = M_DISCARD;
      end else begin
        len_nxt = len_r + 1'b1;
        case (mode_r)
          M_IDLE: begin
            if (c == CH_PLUS) begin
              mode_nxt = M_CODE;
            end else if (c == CH_MINUS || c == CH_HASH) begin
              is_time_nxt = (c == CH_HASH);
              mode_nxt    = M_TAG;
            end else if (c == CH_X) begin
              res_valid         = 1'b1;
              res.kind          = KIND_END;
              res.code          = CH_X;
              res.code_position = POS_W'(cnt_r);
              mode_nxt          = M_IDLE;
            end else begin
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.code  = c;
              mode_nxt  = M_DISCARD;
            end
          end
          M_CODE: begin
            res_valid = 1'b1;
            if (cnt_r >= CNT_W'(MAX_CODES)) begin
              res.kind = KIND_ERROR;
              res.code = c;
              mode_nxt = M_DISCARD;
            end else begin
              res.kind          = KIND_CODE;
              res.code          = c;
              res.code_position = POS_W'(cnt_r);
              cnt_nxt           = cnt_r + 1'b1;
              mode_nxt          = M_SEP;
            end
          end
          M_SEP: begin
            mode_nxt = (c == CH_PLUS) ? M_IDLE : M_CODE;
          end
          M_TAG: begin
            tag_nxt  = c;
            acc_nxt  = '0;
            dig_nxt  = '0;
            stop_nxt = 1'b0;
            mode_nxt = M_BODY_FIRST;
          end
          M_BODY_FIRST: begin
            dig_nxt = dig_r + 1'b1;
            if (!stop_r && is_digit) begin
              acc_nxt = acc_take;
            end else begin
              stop_nxt = 1'b1;
            end
            mode_nxt = M_BODY;
          end
          M_BODY: begin
            if (c == closer) begin
              res_valid   = slot_ok;
              res.kind    = is_time_r ? KIND_TIME : KIND_TEMP;
              res.slot    = slot_sel;
              res.value   = acc_r;
              mode_nxt    = M_IDLE;
              is_time_nxt = 1'b0;
              tag_nxt     = '0;
              acc_nxt     = '0;
              dig_nxt     = '0;
              stop_nxt    = 1'b0;
            end else if (dig_r >= DIG_W'(MAX_DIGITS)) begin
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.code  = c;
              mode_nxt  = M_DISCARD;
            end else begin
              dig_nxt = dig_r + 1'b1;
              if (!stop_r && is_digit) begin
                acc_nxt = acc_take;
              end else begin
                stop_nxt = 1'b1;
              end
            end
          end
          default: begin
            mode_nxt = M_IDLE;
          end
        endcase
      end
      if ((mode_nxt == M_DISCARD && mode_r != M_DISCARD) ||
          (mode_r == M_DISCARD && mode_nxt == M_IDLE) ||
          (res_valid && res.kind == KIND_END) ||
          (mode_r != M_DISCARD && mode_r != M_IDLE && mode_r != M_CODE &&
           mode_r != M_SEP && mode_r != M_TAG && mode_r != M_BODY_FIRST &&
           mode_r != M_BODY)) begin
        is_time_nxt = 1'b0;
        tag_nxt     = '0;
        acc_nxt     = '0;
        dig_nxt     = '0;
        stop_nxt    = 1'b0;
        cnt_nxt     = '0;
        len_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      is_time_r <= 1'b0;
      tag_r     <= '0;
      acc_r     <= '0;
      dig_r     <= '0;
      stop_r    <= 1'b0;
      cnt_r     <= '0;
      len_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      is_time_r <= is_time_nxt;
      tag_r     <= tag_nxt;
      acc_r     <= acc_nxt;
      dig_r     <= dig_nxt;
      stop_r    <= stop_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

// ===== hdl/rfp_out_reg.sv =====
module rfp_out_reg
  import rfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic res_valid,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res,
  output logic room
);

  logic valid_r;
  res_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/recipe_frame_parser_top.sv =====
// Recipe frame parser.
// Input channel: one ASCII character per beat on in_char (in_valid/in_ready).
// Result channel: at most one result beat per character on out_kind, out_code,
// out_code_position, out_slot and out_value (out_valid/out_ready).
// Kinds: process code, temperature value, time value, frame end, frame error.
// A character taken into the input register produces its result beat, if any,
// once the parse step has loaded that beat into the result register.
// Throughput: one character per cycle while the result register has room,
// set by the single parse step between the input register and the result
// register. A character that yields no result still passes the parse step.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to field level with all counters cleared.
// When the receiver stalls, the result register holds its beat; the input
// register then fills and in_ready drops until out_ready returns.
// After a frame error the parser drops characters until 'X'.
module recipe_frame_parser_top
  import rfp_pkg::*;
#(
  parameter int MAX_CODES  = MAX_CODES_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_FRAME  = MAX_FRAME_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  in_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [CHAR_W-1:0]  out_code,
  output logic [POS_W-1:0]   out_code_position,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [VALUE_W-1:0] out_value
);

  logic              hold_valid;
  logic [CHAR_W-1:0] hold_char;
  logic              room;
  logic              step;
  logic              res_valid;
  res_t              res;
  res_t              out_res;

  assign step = hold_valid && room;

  rfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .step       (step),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  rfp_parse #(
    .MAX_CODES  (MAX_CODES),
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_FRAME  (MAX_FRAME)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .c         (hold_char),
    .res_valid (res_valid),
    .res       (res)
  );

  rfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .room      (room)
  );

  assign out_kind          = out_res.kind;
  assign out_code          = out_res.code;
  assign out_code_position = out_res.code_position;
  assign out_slot          = out_res.slot;
  assign out_value         = out_res.value;

endmodule
